// File: src/oets_pkg.sv
// Shared types and constants for the odd-even transposition sorter.
package oets_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 16;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SORT,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     sel;        // this cell takes the loaded value
        logic     is_lower;   // lower member of its pair in this phase
        logic     has_left;   // pair with left neighbor lies inside the set
        logic     has_right;  // pair with right neighbor lies inside the set
    } t_cell_ctl;

endpackage

// File: src/oets_cell.sv
// One sorter cell: holds one element, compare-exchanges with a neighbor, shifts left.
module oets_cell
    import oets_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_load,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    output logic signed [DATA_W-1:0] o_value
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            OP_LOAD: begin
                if (i_ctl.sel) begin
                    n_value = i_load;
                end
            end
            OP_SORT: begin
                if (i_ctl.is_lower) begin
                    // keep the smaller of self and right partner
                    if (i_ctl.has_right && (r_value > i_right)) begin
                        n_value = i_right;
                    end
                end else begin
                    // keep the larger of left partner and self
                    if (i_ctl.has_left && (i_left > r_value)) begin
                        n_value = i_left;
                    end
                end
            end
            OP_SHIFT: n_value = i_right;
            OP_HOLD:  n_value = r_value;
            default:  n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: src/odd_even_transposition_sorter.sv
// Top level of the odd-even transposition sorter: control and the chain of cells.
//
// Input channel: i_valid / o_stall carry one element per item (i_item.value),
// i_item.last closes the set. Output channel: o_valid / i_stall carry the
// sorted elements, ascending, final_res on the last one, overflow on every
// item of a set that lost elements beyond CAPACITY.
// An item is taken at a clock edge where valid is high and stall is low.
// Sequence: elements load one by one into the cell row; after the closing
// item, the row runs N phases for N held elements, all pairs of a phase
// compared at once by the cell row; then the elements leave one by one
// through the output register, shifting the row toward cell 0. Input is
// stalled during sorting and emitting; the next set loads while the last
// result still waits in the output register.
// A stalled receiver freezes the shift chain; nothing is lost.
// Reset (synchronous, active low) empties the set and the output register;
// cell contents are undefined until loaded.
module odd_even_transposition_sorter
    import oets_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;     // held elements, then remaining to emit
    logic [CW-1:0]  r_phase, n_phase;
    logic           r_dropped, n_dropped;
    logic           r_out_valid, n_out_valid;
    t_out_item      r_out;

    t_cell_op       cell_op;
    logic           out_load;
    logic           in_take;
    logic           full;

    logic signed [DATA_W-1:0] cell_val [CAPACITY];
    t_cell_ctl                cell_ctl [CAPACITY];

    assign full    = (r_count == CW'(CAPACITY));
    assign in_take = i_valid && !o_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_take && i_item.last) begin
                    n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                if (r_phase + CW'(1) >= r_count) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && r_count == CW'(1)) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs of the controller
    always_comb begin
        o_stall  = 1'b1;
        cell_op  = OP_HOLD;
        out_load = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_stall = 1'b0;
                // input is never stalled here, so valid alone means taken
                cell_op = i_valid ? OP_LOAD : OP_HOLD;
            end
            ST_SORT: begin
                cell_op = OP_SORT;
            end
            ST_EMIT: begin
                out_load = !r_out_valid || !i_stall;
                cell_op  = out_load ? OP_SHIFT : OP_HOLD;
            end
            default: begin
                cell_op = OP_HOLD;
            end
        endcase
    end

    // datapath counters and flags
    always_comb begin
        n_count     = r_count;
        n_phase     = r_phase;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_LOAD: begin
                n_phase = '0;
                if (in_take) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            ST_SORT: begin
                n_phase = r_phase + CW'(1);
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_count     = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_phase     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // output register, fed from the head of the chain
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.sorted_value <= cell_val[0];
            r_out.final_res    <= (r_count == CW'(1));
            r_out.overflow     <= r_dropped;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // row of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [DATA_W-1:0] left_val;
        logic signed [DATA_W-1:0] right_val;

        // lower member of a pair when the cell's parity matches the phase parity
        always_comb begin
            cell_ctl[gi].op        = cell_op;
            cell_ctl[gi].sel       = (r_count == CW'(gi));
            cell_ctl[gi].is_lower  = ((gi % 2) == 1) == r_phase[0];
            cell_ctl[gi].has_left  = (gi > 0) && (CW'(gi) < r_count);
            cell_ctl[gi].has_right = (CW'(gi + 1) < r_count);
        end

        if (gi == 0) begin : g_first
            assign left_val = cell_val[gi];
        end else begin : g_mid_l
            assign left_val = cell_val[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[gi];
        end else begin : g_mid_r
            assign right_val = cell_val[gi+1];
        end

        oets_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[gi]),
            .i_load  (i_item.value),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (cell_val[gi])
        );
    end

endmodule
